@@ hdl/pcq_pkg.sv @@
// shared types, codes and defaults for the per-client period byte quota unit
`default_nettype none

package pcq_pkg;

    localparam int UID_W    = 32;
    localparam int AMOUNT_W = 44;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    localparam int DEF_ENTRIES     = 16;
    localparam int DEF_PERIOD_BITS = 20;
    localparam int DEF_QUEUE_DEPTH = 2;

    // request kinds as they arrive on the input port
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOOLARGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOENTRY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_REQ,
        OP_TICK,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [UID_W-1:0]    uid;
        logic [AMOUNT_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AMOUNT_W-1:0] remaining;
    } t_out_item;

    // classified request as it travels from front to back
    typedef struct packed {
        t_op                 op;
        logic [UID_W-1:0]    uid;
        logic [AMOUNT_W-1:0] amount;
    } t_op_item;

endpackage

`default_nettype wire

@@ hdl/pcq_front.sv @@
// front stage: accepts input requests, decodes the kind and holds them for the queue
`default_nettype none

module pcq_front
    import pcq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    output logic          o_full,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_q_full,
    output t_op_item      o_op_item
);

    logic     r_valid;
    t_op_item r_op_item;
    t_op_item n_op_item;
    logic     ready;
    logic     take;

    assign ready = !r_valid || !i_q_full;
    assign take  = i_push && ready;

    always_comb begin
        n_op_item.uid    = i_item.uid;
        n_op_item.amount = i_item.amount;
        unique case (i_item.kind)
            KIND_LOAD: n_op_item.op = OP_LOAD;
            KIND_REQ:  n_op_item.op = OP_REQ;
            KIND_TICK: n_op_item.op = OP_TICK;
            KIND_RSVD: n_op_item.op = OP_NOP;
            default:   n_op_item.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op_item <= n_op_item;
        end
    end

    assign o_full    = !ready;
    assign o_valid   = r_valid;
    assign o_op_item = r_op_item;

endmodule

`default_nettype wire

@@ hdl/pcq_queue.sv @@
// short request queue between the front and back stages
`default_nettype none

module pcq_queue
    import pcq_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_wr,
    input  wire t_op_item i_wr_item,
    output logic          o_full,
    input  wire logic     i_rd,
    output logic          o_empty,
    output t_op_item      o_rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op_item         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    assign o_rd_item = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

@@ hdl/pcq_back.sv @@
// back stage: client table lookup, quota update and result register
`default_nettype none

module pcq_back
    import pcq_pkg::*;
#(
    parameter int ENTRIES     = DEF_ENTRIES,
    parameter int PERIOD_BITS = DEF_PERIOD_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [UID_W-1:0] i_cfg_data,
    input  wire logic             i_q_empty,
    input  wire t_op_item         i_op_item,
    output logic                  o_q_rd,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output t_out_item             o_result
);

    localparam int FILL_W = $clog2(ENTRIES + 1);

    logic [UID_W-1:0]       r_fallback_uid;
    logic [UID_W-1:0]       r_key   [ENTRIES];
    logic [AMOUNT_W-1:0]    r_alloc [ENTRIES];
    logic [AMOUNT_W-1:0]    r_left  [ENTRIES];
    logic [PERIOD_BITS-1:0] r_tag   [ENTRIES];
    logic [ENTRIES-1:0]     r_fresh;
    logic [ENTRIES-1:0]     r_used;
    logic [PERIOD_BITS-1:0] r_period;
    logic [FILL_W-1:0]      r_fill_count;
    logic                   r_out_valid;
    t_out_item              r_result;

    logic                   take;
    logic [ENTRIES-1:0]     hit_uid;
    logic [ENTRIES-1:0]     hit_fb;
    logic [ENTRIES-1:0]     fill_sel;
    logic [ENTRIES-1:0]     req_sel;
    logic [ENTRIES-1:0]     load_sel;
    logic                   has_space;
    logic                   load_new;
    logic                   do_load;
    logic                   do_grant;
    logic [AMOUNT_W-1:0]    sel_alloc;
    logic [AMOUNT_W-1:0]    sel_left;
    logic [PERIOD_BITS-1:0] sel_tag;
    logic                   sel_fresh;
    logic [AMOUNT_W-1:0]    avail;
    logic [AMOUNT_W-1:0]    n_left;
    t_out_item              n_result;

    assign take   = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_rd = take;

    // keys are unique among used entries, so at most one hit per search
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit_uid[i]  = r_used[i] && (r_key[i] == i_op_item.uid);
            hit_fb[i]   = r_used[i] && (r_key[i] == r_fallback_uid);
            fill_sel[i] = (r_fill_count == FILL_W'(i));
        end
    end

    assign has_space = (r_fill_count < FILL_W'(ENTRIES));
    assign load_new  = !(|hit_uid) && has_space;
    assign load_sel  = (|hit_uid) ? hit_uid : (has_space ? fill_sel : '0);
    assign req_sel   = (|hit_uid) ? hit_uid : hit_fb;

    always_comb begin
        sel_alloc = '0;
        sel_left  = '0;
        sel_tag   = '0;
        sel_fresh = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (req_sel[i]) begin
                sel_alloc = sel_alloc | r_alloc[i];
                sel_left  = sel_left | r_left[i];
                sel_tag   = sel_tag | r_tag[i];
                sel_fresh = sel_fresh | r_fresh[i];
            end
        end
    end

    // a fresh or stale entry counts as refilled to its allocation
    assign avail  = (sel_fresh || (sel_tag != r_period)) ? sel_alloc : sel_left;
    assign n_left = avail - i_op_item.amount;

    always_comb begin
        n_result.status    = ST_NOENTRY;
        n_result.remaining = '0;
        do_load            = 1'b0;
        do_grant           = 1'b0;
        unique case (i_op_item.op)
            OP_LOAD: begin
                if (|load_sel) begin
                    n_result.status = ST_LOADED;
                    do_load         = take;
                end else begin
                    n_result.status = ST_FULL;
                end
            end
            OP_REQ: begin
                if (|req_sel) begin
                    if (avail < i_op_item.amount) begin
                        n_result.status = (i_op_item.amount > sel_alloc) ? ST_TOOLARGE
                                                                         : ST_WAIT;
                        n_result.remaining = avail;
                    end else begin
                        n_result.status    = ST_GRANTED;
                        n_result.remaining = n_left;
                        do_grant           = take;
                    end
                end
            end
            OP_TICK: begin
                n_result.status = ST_GRANTED;
            end
            OP_NOP: begin
                n_result.status = ST_NOENTRY;
            end
            default: begin
                n_result.status = ST_NOENTRY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback_uid <= '0;
            r_used         <= '0;
            r_period       <= '0;
            r_fill_count   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fallback_uid <= i_cfg_data;
            end
            if (do_load && load_new) begin
                r_used       <= r_used | load_sel;
                r_fill_count <= r_fill_count + 1'b1;
            end
            if (take && (i_op_item.op == OP_TICK)) begin
                r_period <= r_period + 1'b1;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (do_load && load_sel[i]) begin
                r_key[i]   <= i_op_item.uid;
                r_alloc[i] <= i_op_item.amount;
                r_left[i]  <= '0;
                r_tag[i]   <= '0;
                r_fresh[i] <= 1'b1;
            end else if (do_grant && req_sel[i]) begin
                r_left[i]  <= n_left;
                r_tag[i]   <= r_period;
                r_fresh[i] <= 1'b0;
            end
        end
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ hdl/per_client_period_byte_quota_unit.sv @@
// top level of the per-client period byte quota unit
//
//  port group          | direction | handshake          | payload
//  --------------------+-----------+--------------------+-----------------------
//  request in          | in        | push / full        | i_item (t_in_item)
//  result out          | out       | empty / pop        | o_result (t_out_item)
//  fallback id write   | in        | i_cfg_we           | i_cfg_data
//
//  one request per clock sustained while pop keeps up with the results; a result passes
//  through the front register, request queue and result register on its way out
//  the front register, request queue and result register each stall on their own
//  the table lookup and quota update are combinational in the back stage
//  reset clears valid bits, counters and the fallback id; table contents stay
//  undefined and need no clearing pass
`default_nettype none

module per_client_period_byte_quota_unit
    import pcq_pkg::*;
#(
    parameter int ENTRIES     = DEF_ENTRIES,
    parameter int PERIOD_BITS = DEF_PERIOD_BITS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [UID_W-1:0] i_cfg_data,
    input  wire logic             push,
    output logic                  full,
    input  wire t_in_item         i_item,
    output logic                  empty,
    input  wire logic             pop,
    output t_out_item             o_result
);

    logic     front_valid;
    t_op_item front_item;
    logic     q_full;
    logic     q_empty;
    logic     q_rd;
    t_op_item q_item;

    pcq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_item    (i_item),
        .o_valid   (front_valid),
        .i_q_full  (q_full),
        .o_op_item (front_item)
    );

    pcq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_valid),
        .i_wr_item (front_item),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_empty   (q_empty),
        .o_rd_item (q_item)
    );

    pcq_back #(
        .ENTRIES     (ENTRIES),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_empty  (q_empty),
        .i_op_item  (q_item),
        .o_q_rd     (q_rd),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire
